>>> src/ces_pkg.sv
// shared types and constants for the conditional extremum search block
// no dependencies
`default_nettype none

package ces_pkg;

    localparam int DEPTH    = 512;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int DATA_W   = 32;
    localparam int INDEX_W  = 9;
    localparam int OP_W     = 3;
    localparam int CFG_W    = 10;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic REG_COUNT_A = 1'b0;
    localparam logic REG_COUNT_B = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_WR_A      = 3'd0,
        OP_WR_B      = 3'd1,
        OP_MAX_ABOVE = 3'd2,
        OP_MAX_BELOW = 3'd3,
        OP_MIN_ABOVE = 3'd4,
        OP_MIN_BELOW = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REF,
        S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [CNT_W-1:0] na;
        logic [CNT_W-1:0] nb;
    } counts_t;

    typedef struct packed {
        logic                     we_a;
        logic                     we_b;
        logic [ADDR_W-1:0]        waddr;
        logic signed [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0]        raddr;
    } ram_req_t;

endpackage

`default_nettype wire

>>> src/ces_ram.sv
// generic single-port-write, single-port-read synchronous ram
// registered read data; no dependencies
`default_nettype none

module ces_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> src/ces_cfg.sv
// apb register file holding count_a and count_b
// depends on ces_pkg
`default_nettype none

module ces_cfg
    import ces_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output counts_t                 counts
);

    logic [CFG_W-1:0] count_a_reg, count_a_next;
    logic [CFG_W-1:0] count_b_reg, count_b_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_comb
    begin
        count_a_next = count_a_reg;
        count_b_next = count_b_reg;
        if (wr_en)
        begin
            case (paddr[2])
                REG_COUNT_A: count_a_next = pwdata[CFG_W-1:0];
                REG_COUNT_B: count_b_next = pwdata[CFG_W-1:0];
                default:     count_a_next = count_a_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_a_reg <= '0;
            count_b_reg <= '0;
        end
        else
        begin
            count_a_reg <= count_a_next;
            count_b_reg <= count_b_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_COUNT_A: prdata = PDATA_W'(count_a_reg);
            REG_COUNT_B: prdata = PDATA_W'(count_b_reg);
            default:     prdata = '0;
        endcase
    end

    // clamp to the array depth
    assign counts.na = (32'(count_a_reg) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(count_a_reg);
    assign counts.nb = (32'(count_b_reg) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(count_b_reg);

endmodule

`default_nettype wire

>>> src/ces_ctrl.sv
// sequencer: write items, reference read, one-entry-per-cycle scan, result
// depends on ces_pkg
`default_nettype none

module ces_ctrl
    import ces_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [OP_W-1:0]          operation,
    input  wire logic [INDEX_W-1:0]       index,
    input  wire logic signed [DATA_W-1:0] value,
    input  wire counts_t                  counts,
    input  wire logic signed [DATA_W-1:0] rdata_a,
    input  wire logic signed [DATA_W-1:0] rdata_b,
    output ram_req_t                      ram_req,
    output logic                          busy,
    output logic                          done,
    output logic                          found,
    output logic [INDEX_W-1:0]            position
);

    state_t                   state_reg, state_next;
    op_t                      op_reg, op_next;
    logic [INDEX_W-1:0]       idx_reg, idx_next;
    logic [ADDR_W-1:0]        cmp_idx_reg, cmp_idx_next;
    logic signed [DATA_W-1:0] ref_val_reg, ref_val_next;
    logic signed [DATA_W-1:0] best_val_reg, best_val_next;
    logic [ADDR_W-1:0]        best_pos_reg, best_pos_next;
    logic                     have_reg, have_next;

    logic                     scan_b;
    logic                     want_above;
    logic [CNT_W-1:0]         n_scan;
    logic [CNT_W-1:0]         n_ref;
    logic signed [DATA_W-1:0] scan_val;
    logic                     qualifies;
    logic                     better;
    logic                     last;
    logic                     in_range;

    // modes 2 and 3 reference A and scan B
    assign scan_b     = (op_reg == OP_MAX_ABOVE) || (op_reg == OP_MAX_BELOW);
    assign want_above = (op_reg == OP_MAX_ABOVE) || (op_reg == OP_MIN_ABOVE);
    assign n_scan     = scan_b ? counts.nb : counts.na;
    assign n_ref      = scan_b ? counts.na : counts.nb;
    assign scan_val   = scan_b ? rdata_b : rdata_a;
    assign in_range   = 32'(idx_reg) < 32'(n_ref);
    assign qualifies  = want_above ? (scan_val > ref_val_reg) : (scan_val < ref_val_reg);
    assign better     = !have_reg ||
                        (scan_b ? (scan_val > best_val_reg) : (scan_val < best_val_reg));
    assign last       = ({1'b0, cmp_idx_reg} == (n_scan - CNT_W'(1)));

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        idx_next      = idx_reg;
        cmp_idx_next  = cmp_idx_reg;
        ref_val_next  = ref_val_reg;
        best_val_next = best_val_reg;
        best_pos_next = best_pos_reg;
        have_next     = have_reg;

        ram_req.we_a  = 1'b0;
        ram_req.we_b  = 1'b0;
        ram_req.waddr = ADDR_W'(index);
        ram_req.wdata = value;
        ram_req.raddr = ADDR_W'(index);

        busy     = (state_reg != S_IDLE);
        done     = 1'b0;
        found    = have_reg;
        position = INDEX_W'(best_pos_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = op_t'(operation);
                    idx_next = index;
                    case (op_t'(operation))
                        OP_WR_A:
                        begin
                            ram_req.we_a = (32'(index) < DEPTH);
                        end
                        OP_WR_B:
                        begin
                            ram_req.we_b = (32'(index) < DEPTH);
                        end
                        OP_MAX_ABOVE, OP_MAX_BELOW, OP_MIN_ABOVE, OP_MIN_BELOW:
                        begin
                            state_next = S_REF;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_REF:
            begin
                ref_val_next  = scan_b ? rdata_a : rdata_b;
                have_next     = 1'b0;
                best_pos_next = '0;
                best_val_next = '0;
                cmp_idx_next  = '0;
                ram_req.raddr = '0;
                if (in_range && (n_scan != '0))
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                ram_req.raddr = cmp_idx_reg + ADDR_W'(1);
                if (qualifies && better)
                begin
                    have_next     = 1'b1;
                    best_val_next = scan_val;
                    best_pos_next = cmp_idx_reg;
                end
                cmp_idx_next = cmp_idx_reg + ADDR_W'(1);
                if (last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                done       = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            have_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            have_reg  <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        ref_val_reg  <= ref_val_next;
        best_val_reg <= best_val_next;
        best_pos_reg <= best_pos_next;
    end

endmodule

`default_nettype wire

>>> src/conditional_extremum_search.sv
// conditional extremum search: two 512 x 32 arrays in synchronous rams
// write items give no result; busy stays low
// a query steps through accept, reference read, one ram read per scanned entry
// up to the clamped count of the scanned array, and a result strobe
// done is high for one cycle with found and position; no stall is possible
// rst_n clears counts and the sequencer; array contents are undefined
`default_nettype none

module conditional_extremum_search
    import ces_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [OP_W-1:0]          operation,
    input  wire logic [INDEX_W-1:0]       index,
    input  wire logic signed [DATA_W-1:0] value,
    output logic                          done,
    output logic                          found,
    output logic [INDEX_W-1:0]            position,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [PADDR_W-1:0]       paddr,
    input  wire logic [PDATA_W-1:0]       pwdata,
    output logic      [PDATA_W-1:0]       prdata,
    output logic                          pready
);

    counts_t           counts;
    ram_req_t          ram_req;
    logic [DATA_W-1:0] rdata_a;
    logic [DATA_W-1:0] rdata_b;

    ces_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .counts  (counts)
    );

    ces_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_W)
    ) u_ram_a (
        .clk   (clk),
        .we    (ram_req.we_a),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (rdata_a)
    );

    ces_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_W)
    ) u_ram_b (
        .clk   (clk),
        .we    (ram_req.we_b),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .raddr (ram_req.raddr),
        .rdata (rdata_b)
    );

    ces_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .index     (index),
        .value     (value),
        .counts    (counts),
        .rdata_a   (rdata_a),
        .rdata_b   (rdata_b),
        .ram_req   (ram_req),
        .busy      (busy),
        .done      (done),
        .found     (found),
        .position  (position)
    );

endmodule

`default_nettype wire

>>> tb/conditional_extremum_search_tb.sv
// self-checking testbench for conditional_extremum_search: array writes, four search modes
// and count registers over apb, every result checked against a cycle-free predictor
// depends on ces_pkg and conditional_extremum_search

module conditional_extremum_search_tb;
    import ces_pkg::*;

    localparam logic [OP_W-1:0] OP_RSVD_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_HI = 3'd7;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam int SIDE_A = 0;
    localparam int SIDE_B = 1;
    localparam int MIX_ITEMS = 115;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic [INDEX_W-1:0]       idx;
        logic signed [DATA_W-1:0] val;
    } cmd_t;

    typedef struct {
        logic               hit;
        logic [INDEX_W-1:0] pos;
    } answer_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [OP_W-1:0]          operation = '0;
    logic [INDEX_W-1:0]       index = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic                     done;
    logic                     found;
    logic [INDEX_W-1:0]       position;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [PADDR_W-1:0]       paddr = '0;
    logic [PDATA_W-1:0]       pwdata = '0;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;

    // predictor state
    logic signed [DATA_W-1:0] shadow_a [DEPTH];
    logic signed [DATA_W-1:0] shadow_b [DEPTH];
    logic [CFG_W-1:0]         cnt_a = '0;
    logic [CFG_W-1:0]         cnt_b = '0;

    // stimulus bookkeeping: which entries hold data, and the written prefix
    bit                       written [2][DEPTH];
    int                       pref [2];

    cmd_t                     cmd_backlog [$];
    answer_t                  answers_due [$];
    cmd_t                     next_cmd;
    answer_t                  exp_ans;
    int                       idle_pct = 9;
    int                       errors = 0;

    conditional_extremum_search dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int clamp_count(input logic [CFG_W-1:0] c);
        return (c > DEPTH) ? DEPTH : int'(c);
    endfunction

    function automatic answer_t find_extremum(input logic [OP_W-1:0] op,
                                              input logic [INDEX_W-1:0] idx);
        answer_t                  ans;
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] v;
        logic signed [DATA_W-1:0] best;
        bit                       on_b;
        bit                       above;
        int                       n;
        ans.hit = 1'b0;
        ans.pos = '0;
        best = '0;
        // modes 2 and 3 take the reference from a and scan b for the largest
        on_b = (op == OP_MAX_ABOVE || op == OP_MAX_BELOW);
        above = (op == OP_MAX_ABOVE || op == OP_MIN_ABOVE);
        if (idx >= (on_b ? clamp_count(cnt_a) : clamp_count(cnt_b)))
            return ans;
        key = on_b ? shadow_a[idx] : shadow_b[idx];
        n = on_b ? clamp_count(cnt_b) : clamp_count(cnt_a);
        for (int j = 0; j < n; j++)
        begin
            v = on_b ? shadow_b[j] : shadow_a[j];
            if (above ? (v > key) : (v < key))
            begin
                // strict update keeps the lowest index on ties
                if (!ans.hit || (on_b ? (v > best) : (v < best)))
                begin
                    best = v;
                    ans.pos = INDEX_W'(j);
                    ans.hit = 1'b1;
                end
            end
        end
        return ans;
    endfunction

    task automatic apply_cmd(input cmd_t c);
        case (c.op)
            OP_WR_A: shadow_a[c.idx] = c.val;
            OP_WR_B: shadow_b[c.idx] = c.val;
            OP_MAX_ABOVE, OP_MAX_BELOW, OP_MIN_ABOVE, OP_MIN_BELOW:
                answers_due.push_back(find_extremum(c.op, c.idx));
            default: ;
        endcase
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (start && !busy)
                apply_cmd(cmd_t'{operation, index, value});
            if (!start || !busy)
            begin
                if (cmd_backlog.size() == 0 || $urandom_range(0, 99) < idle_pct)
                    start <= 1'b0;
                else
                begin
                    next_cmd = cmd_backlog.pop_front();
                    operation <= next_cmd.op;
                    index <= next_cmd.idx;
                    value <= next_cmd.val;
                    start <= 1'b1;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (answers_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual found=%0b position=%0d",
                         $time, found, position);
            end
            else
            begin
                exp_ans = answers_due.pop_front();
                if (found !== exp_ans.hit)
                begin
                    errors++;
                    $display("%0t: found mismatch, expected %0b actual %0b",
                             $time, exp_ans.hit, found);
                end
                if (position !== exp_ans.pos)
                begin
                    errors++;
                    $display("%0t: position mismatch, expected %0d actual %0d",
                             $time, exp_ans.pos, position);
                end
            end
        end
    end

    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom_range(0, 6) - 3;
            4, 5:
                case ($urandom_range(0, 3))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return 0;
                    default: return -1;
                endcase
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        else if (r < 60)
            return CFG_W'($urandom_range(1, 12));
        else if (r < 80)
            return CFG_W'($urandom_range(13, 64));
        else if (r < 90)
            return CFG_W'(DEPTH);
        return CFG_W'($urandom_range(DEPTH + 1, 1023));
    endfunction

    task automatic queue_write(input int side, input int idx, input logic signed [DATA_W-1:0] v);
        cmd_t c;
        c.op = (side == SIDE_B) ? OP_WR_B : OP_WR_A;
        c.idx = INDEX_W'(idx);
        c.val = v;
        cmd_backlog.push_back(c);
        written[side][idx] = 1'b1;
        while (pref[side] < DEPTH && written[side][pref[side]])
            pref[side]++;
    endtask

    task automatic queue_op(input logic [OP_W-1:0] op, input int idx);
        cmd_t c;
        c.op = op;
        c.idx = INDEX_W'(idx);
        c.val = $urandom;
        cmd_backlog.push_back(c);
    endtask

    task automatic queue_query();
        logic [OP_W-1:0] op;
        int              side;
        int              lim;
        int              idx;
        op = OP_W'($urandom_range(OP_MAX_ABOVE, OP_MIN_BELOW));
        side = (op == OP_MAX_ABOVE || op == OP_MAX_BELOW) ? SIDE_A : SIDE_B;
        lim = clamp_count(side == SIDE_A ? cnt_a : cnt_b);
        if (lim > 0 && $urandom_range(0, 99) < 80)
            idx = $urandom_range(0, lim - 1);
        else
            idx = $urandom_range(0, DEPTH - 1);
        // the reference entry must hold data even when it lies past the count
        if (!written[side][idx])
            idx = $urandom_range(0, pref[side] - 1);
        queue_op(op, idx);
    endtask

    task automatic fill_to(input int side, input int n);
        while (pref[side] < n)
            queue_write(side, pref[side], rand_value());
    endtask

    task automatic drain();
        while (cmd_backlog.size() != 0 || start || answers_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_counts(input logic [CFG_W-1:0] a, input logic [CFG_W-1:0] b);
        drain();
        for (int r = 0; r < 2; r++)
        begin
            @(posedge clk);
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= (r == 0) ? {REG_COUNT_A, 2'b00} : {REG_COUNT_B, 2'b00};
            pwdata <= (r == 0) ? PDATA_W'(a) : PDATA_W'(b);
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
        end
        cnt_a = a;
        cnt_b = b;
    endtask

    initial
    begin
        #8000000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int               r;
        int               side;
        int               span;
        int               phase;
        int               mix_count;
        int               top;
        logic [CFG_W-1:0] na;
        logic [CFG_W-1:0] nb;
        pref[SIDE_A] = 0;
        pref[SIDE_B] = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, ties, no qualifier, reference past count, spare codes
        set_counts(CFG_W'(5), CFG_W'(5));
        queue_write(SIDE_A, 0, VAL_MIN);
        queue_write(SIDE_A, 1, 7);
        queue_write(SIDE_A, 2, 7);
        queue_write(SIDE_A, 3, VAL_MAX);
        queue_write(SIDE_A, 4, -1);
        queue_write(SIDE_B, 0, 7);
        queue_write(SIDE_B, 1, VAL_MAX);
        queue_write(SIDE_B, 2, VAL_MIN);
        queue_write(SIDE_B, 3, VAL_MAX);
        queue_write(SIDE_B, 4, 0);
        queue_write(SIDE_A, DEPTH - 1, VAL_MAX);
        queue_write(SIDE_B, DEPTH - 1, VAL_MIN);
        queue_op(OP_MAX_ABOVE, 0);
        queue_op(OP_MAX_BELOW, 3);
        queue_op(OP_MIN_ABOVE, 2);
        queue_op(OP_MIN_BELOW, 0);
        queue_op(OP_MAX_ABOVE, 3);
        queue_op(OP_MIN_BELOW, 2);
        queue_op(OP_MIN_ABOVE, 1);
        queue_op(OP_MIN_BELOW, 1);
        queue_op(OP_MAX_ABOVE, DEPTH - 1);
        queue_op(OP_MIN_BELOW, DEPTH - 1);
        queue_op(OP_RSVD_LO, 0);
        queue_op(OP_RSVD_HI, DEPTH - 1);
        set_counts('0, '0);
        queue_op(OP_MAX_BELOW, 0);
        queue_op(OP_MIN_ABOVE, 0);

        // random phases, each with its own pair of counts
        phase = 0;
        mix_count = 0;
        while (mix_count < MIX_ITEMS)
        begin
            case (phase)
                0: begin na = CFG_W'(DEPTH); nb = '1; end
                1: begin na = '1; nb = '0; end
                default: begin na = pick_count(); nb = pick_count(); end
            endcase
            set_counts(na, nb);
            idle_pct = (phase >= 2 && phase < 4) ? 0 : 9;
            fill_to(SIDE_A, clamp_count(na));
            fill_to(SIDE_B, clamp_count(nb));
            top = (clamp_count(na) > clamp_count(nb)) ? clamp_count(na) : clamp_count(nb);
            span = (top > 64) ? 6 : (top > 12) ? 15 : 30;
            repeat (span)
            begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    queue_op(($urandom_range(0, 1) != 0) ? OP_RSVD_HI : OP_RSVD_LO,
                             $urandom_range(0, DEPTH - 1));
                else
                begin
                    mix_count++;
                    if (r < 40)
                    begin
                        side = $urandom_range(SIDE_A, SIDE_B);
                        if ($urandom_range(0, 99) < 90)
                            queue_write(side, $urandom_range(0,
                                (pref[side] < DEPTH - 1) ? pref[side] + 1 : DEPTH - 1),
                                rand_value());
                        else
                            queue_write(side, $urandom_range(0, DEPTH - 1), rand_value());
                    end
                    else
                        queue_query();
                end
            end
            phase++;
        end

        drain();
        repeat (600) @(posedge clk);
        if (errors == 0 && answers_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> files.f
src/ces_pkg.sv
src/ces_ram.sv
src/ces_cfg.sv
src/ces_ctrl.sv
src/conditional_extremum_search.sv
tb/conditional_extremum_search_tb.sv
